// ----- design/awsr_pkg.sv -----
// ----------------------------------------------------------------------------
// awsr_pkg: shared types and constants of the alpha-weighted SSAA resolve
// Widths of the weighted sums, the long-division datapath and the word that
// travels down the divider pipeline.
// ----------------------------------------------------------------------------
package awsr_pkg;

  localparam int unsigned SAMPLE_COUNT = 4;
  localparam int unsigned CHAN_W       = 8;
  localparam int unsigned COLOR_CHANS  = 3;
  localparam int unsigned PROD_W       = 2 * CHAN_W;
  // Sum of four 8x8 products, at most 260100.
  localparam int unsigned PSUM_W       = PROD_W + 2;
  // Sum of four alphas, at most 1020.
  localparam int unsigned ASUM_W       = CHAN_W + 2;
  // Numerator 2*P + S, at most 521220.
  localparam int unsigned NUM_W        = PSUM_W + 1;
  // Divisor 2*S, at most 2040.
  localparam int unsigned DIV_W        = ASUM_W + 1;
  // The weighted mean never exceeds 255, so eight quotient bits suffice.
  localparam int unsigned QUO_W        = CHAN_W;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES   = QUO_W / BITS_PER_STAGE;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic                             valid;
    logic [DIV_W-1:0]                 divisor;
    logic [CHAN_W-1:0]                alpha;
    div_lane_t [COLOR_CHANS-1:0]      lane;
  } div_word_t;

endpackage

// ----- design/awsr_div_stage.sv -----
// ----------------------------------------------------------------------------
// awsr_div_stage: one stage of the pipelined restoring divider
// Settles BITS_PER_STAGE quotient bits, from bit STAGE_MSB downward, for all
// three color lanes, and registers the result.
// ----------------------------------------------------------------------------
module awsr_div_stage #(
  parameter int unsigned STAGE_MSB = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  awsr_pkg::div_word_t word_i,
  output awsr_pkg::div_word_t word_o
);

  awsr_pkg::div_word_t word_d;
  awsr_pkg::div_word_t word_q;
  logic                valid_q;

  always_comb begin
    logic [awsr_pkg::NUM_W-1:0] trial;
    word_d = word_i;
    trial  = '0;
    for (int j = 0; j < int'(awsr_pkg::BITS_PER_STAGE); j++) begin
      // Divisor aligned to the quotient bit under test.
      trial = awsr_pkg::NUM_W'(word_i.divisor) << (int'(STAGE_MSB) - j);
      for (int ch = 0; ch < int'(awsr_pkg::COLOR_CHANS); ch++) begin
        if (word_d.lane[ch].rem >= trial) begin
          word_d.lane[ch].rem                       = word_d.lane[ch].rem - trial;
          word_d.lane[ch].quo[int'(STAGE_MSB) - j] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  always_comb begin
    word_o       = word_q;
    word_o.valid = valid_q;
  end

endmodule

// ----- design/alpha_weighted_ssaa_resolve_unit.sv -----
// ----------------------------------------------------------------------------
// alpha_weighted_ssaa_resolve_unit: 2x2 alpha-weighted supersample resolve
// Turns the four RGBA8 samples of a 2x2 block into one RGBA8 pixel whose color
// is the alpha-weighted mean, rounded half up, and whose alpha is the mean
// alpha, rounded half up.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                   | Handshake
//  ---------+-----------------------------------------+------------------------
//  samples  | sample_top_left_i .. sample_bottom_right_i | start_i while !busy_o
//  pixel    | red_out_o, green_out_o, blue_out_o, alpha_out_o | done_o, 1 cycle
//
// A word is taken at every clock edge at which start_i is high; busy_o stays
// low because the pipeline never holds. The pixel appears with done_o after
// the multiplier register, the sum register, four divider stages of two
// quotient bits each and the output register. One word per cycle is
// sustained. Reset clears only the valid bits; the receiver cannot stall, so
// nothing ever waits inside the pipeline.
//
module alpha_weighted_ssaa_resolve_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] sample_top_left_i,
  input  logic [31:0] sample_top_right_i,
  input  logic [31:0] sample_bottom_left_i,
  input  logic [31:0] sample_bottom_right_i,
  output logic        done_o,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic [7:0]  alpha_out_o
);

  localparam int unsigned CW = awsr_pkg::CHAN_W;
  localparam int unsigned NS = awsr_pkg::SAMPLE_COUNT;
  localparam int unsigned NC = awsr_pkg::COLOR_CHANS;

  // The pipeline advances unconditionally, so it never refuses a word.
  assign busy_o = 1'b0;

  // Stage 1: unpack the samples and form all color-times-alpha products.
  logic [NS-1:0][31:0] samples;
  assign samples = {sample_bottom_right_i, sample_bottom_left_i,
                    sample_top_right_i, sample_top_left_i};

  logic                                     s1_valid_q;
  logic [NS-1:0][NC-1:0][awsr_pkg::PROD_W-1:0] prod_d, prod_q;
  logic [NS-1:0][CW-1:0]                    alpha_d, alpha_q;

  always_comb begin
    for (int s = 0; s < int'(NS); s++) begin
      alpha_d[s] = samples[s][4*CW-1 -: CW];
      for (int ch = 0; ch < int'(NC); ch++) begin
        prod_d[s][ch] = awsr_pkg::PROD_W'(samples[s][ch*CW +: CW]) *
                        awsr_pkg::PROD_W'(alpha_d[s]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    alpha_q <= alpha_d;
  end

  // Stage 2: accumulate the products and the alphas, then set up the division
  // of 2*P + S by 2*S for each color channel. The mean alpha is final here.
  awsr_pkg::div_word_t div_d;
  awsr_pkg::div_word_t div_pipe [awsr_pkg::DIV_STAGES+1];

  always_comb begin
    logic [awsr_pkg::ASUM_W-1:0] asum;
    logic [awsr_pkg::ASUM_W-1:0] arnd;
    logic [awsr_pkg::PSUM_W-1:0] psum;
    asum = '0;
    for (int s = 0; s < int'(NS); s++) begin
      asum = asum + awsr_pkg::ASUM_W'(alpha_q[s]);
    end
    // Round half up of S/4.
    arnd          = asum + awsr_pkg::ASUM_W'(NS / 2);
    div_d         = '0;
    div_d.valid   = s1_valid_q;
    div_d.divisor = {asum, 1'b0};
    div_d.alpha   = arnd[awsr_pkg::ASUM_W-1 -: CW];
    for (int ch = 0; ch < int'(NC); ch++) begin
      psum = '0;
      for (int s = 0; s < int'(NS); s++) begin
        psum = psum + awsr_pkg::PSUM_W'(prod_q[s][ch]);
      end
      div_d.lane[ch].rem = {psum, 1'b0} + awsr_pkg::NUM_W'(asum);
      div_d.lane[ch].quo = '0;
    end
  end

  logic                s2_valid_q;
  awsr_pkg::div_word_t s2_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= div_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_word_q <= div_d;
  end

  always_comb begin
    div_pipe[0]       = s2_word_q;
    div_pipe[0].valid = s2_valid_q;
  end

  // Stages 3 to 6: restoring long division, two quotient bits per stage,
  // most significant bits first. The numerator is below 256 times the
  // divisor, so the quotient fits in eight bits.
  for (genvar g = 0; g < int'(awsr_pkg::DIV_STAGES); g++) begin : g_div
    awsr_div_stage #(
      .STAGE_MSB(awsr_pkg::QUO_W - 1 - g * awsr_pkg::BITS_PER_STAGE)
    ) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .word_i(div_pipe[g]),
      .word_o(div_pipe[g+1])
    );
  end

  // Stage 7: output register. A zero alpha sum gives a zero divisor, and the
  // colors are then forced to black.
  awsr_pkg::div_word_t last;
  logic                done_q;
  logic [CW-1:0]       red_q, green_q, blue_q, alpha_out_q;
  logic                zero_sum;

  assign last     = div_pipe[awsr_pkg::DIV_STAGES];
  assign zero_sum = (last.divisor == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q       <= zero_sum ? '0 : last.lane[0].quo;
    green_q     <= zero_sum ? '0 : last.lane[1].quo;
    blue_q      <= zero_sum ? '0 : last.lane[2].quo;
    alpha_out_q <= last.alpha;
  end

  assign done_o      = done_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign alpha_out_o = alpha_out_q;

endmodule
